[rtl/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 4;
  localparam int OP_W      = 3;
  localparam int ST_W      = 2;
  localparam int DEPTH_DEF = 16;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;
  localparam logic [OP_W-1:0] OP_READ       = 3'd5;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd6;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     rd_sel;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/bounded_deque_with_indexed_access_core.sv]
// Latency: a result appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle; every operation finishes in the single
// update of the cell chain, which shifts, loads or reads all cells at once.
// Input stalls only while a result waits in the output register.
// Reset (rst_n low at a clock edge) empties the queue; cell contents are kept.
`default_nettype none

module bounded_deque_with_indexed_access_core #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_stall,
  input  wire logic [bdq_pkg::OP_W-1:0]          in_opcode,
  input  wire logic [bdq_pkg::POS_W-1:0]         in_position,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire                                    out_stall,
  output logic signed [bdq_pkg::DATA_W-1:0]      out_read_value,
  output logic [bdq_pkg::ST_W-1:0]               out_status,
  output logic [CNT_W-1:0]                       out_occupancy
);
  import bdq_pkg::*;

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] rd_value_r;
  logic [ST_W-1:0]          status_r, status_nxt;
  logic [CNT_W-1:0]         occ_r;

  logic accept;
  logic full, empty, out_of_range;
  logic do_push_front, do_push_back, do_pop_front, do_pop_back;
  logic do_delete, do_read, do_write;
  logic [CMP_W-1:0] pos_ext, cnt_ext, last_ext;

  cell_ctrl_t               cell_ctrl [DEPTH];
  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_rd   [DEPTH];
  logic signed [DATA_W-1:0] rd_bus;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign last_ext = cnt_ext - CMP_W'(1);

  assign full         = (count_r == CNT_W'(DEPTH));
  assign empty        = (count_r == '0);
  assign out_of_range = (pos_ext >= cnt_ext);

  always_comb begin
    do_push_front = 1'b0;
    do_push_back  = 1'b0;
    do_pop_front  = 1'b0;
    do_pop_back   = 1'b0;
    do_delete     = 1'b0;
    do_read       = 1'b0;
    do_write      = 1'b0;
    status_nxt    = ST_OK;
    unique case (in_opcode)
      OP_PUSH_FRONT: begin
        if (full) status_nxt = ST_FULL;
        else do_push_front = accept;
      end
      OP_PUSH_BACK: begin
        if (full) status_nxt = ST_FULL;
        else do_push_back = accept;
      end
      OP_POP_FRONT: begin
        if (empty) status_nxt = ST_EMPTY;
        else do_pop_front = accept;
      end
      OP_POP_BACK: begin
        if (empty) status_nxt = ST_EMPTY;
        else do_pop_back = accept;
      end
      OP_DELETE: begin
        priority if (empty) status_nxt = ST_EMPTY;
        else if (out_of_range) status_nxt = ST_RANGE;
        else do_delete = accept;
      end
      OP_READ: begin
        priority if (empty) status_nxt = ST_EMPTY;
        else if (out_of_range) status_nxt = ST_RANGE;
        else do_read = accept;
      end
      OP_WRITE: begin
        priority if (empty) status_nxt = ST_EMPTY;
        else if (out_of_range) status_nxt = ST_RANGE;
        else do_write = accept;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (do_push_front || do_push_back) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop_front || do_pop_back || do_delete) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CMP_W-1:0] idx;
    assign idx = CMP_W'(i);

    always_comb begin
      cell_ctrl[i].op = CELL_HOLD;
      priority if (do_push_front) begin
        cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_LEFT;
      end else if ((do_push_back && idx == cnt_ext) || (do_write && idx == pos_ext)) begin
        cell_ctrl[i].op = CELL_LOAD;
      end else if (do_pop_front || (do_delete && idx >= pos_ext)) begin
        cell_ctrl[i].op = CELL_RIGHT;
      end
      cell_ctrl[i].rd_sel = ((do_read || do_delete) && idx == pos_ext) ||
                            (do_pop_back && idx == last_ext) ||
                            (do_pop_front && i == 0);
    end

    bdq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .left_data  ((i == 0) ? in_value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .load_data  (in_value),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_value_r <= rd_bus;
      status_r   <= status_nxt;
      occ_r      <= count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = rd_value_r;
  assign out_status     = status_r;
  assign out_occupancy  = occ_r;

endmodule

`default_nettype wire

[rtl/bdq_cell.sv]
`default_nettype none

module bdq_cell (
  input  wire                               clk,
  input  wire bdq_pkg::cell_ctrl_t          ctrl,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] right_data,
  input  wire logic signed [bdq_pkg::DATA_W-1:0] load_data,
  output logic signed [bdq_pkg::DATA_W-1:0]      data,
  output logic signed [bdq_pkg::DATA_W-1:0]      rd_data
);
  import bdq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    unique case (ctrl.op)
      CELL_HOLD:  data_nxt = data_r;
      CELL_LEFT:  data_nxt = left_data;
      CELL_RIGHT: data_nxt = right_data;
      CELL_LOAD:  data_nxt = load_data;
      default:    data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // Mask so the top can OR all cells into one read bus
  assign rd_data = ctrl.rd_sel ? data_r : '0;

endmodule

`default_nettype wire

[rtl/bdq_checker.sv]
`default_nettype none

module bdq_checker #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input wire                                    clk,
  input wire                                    rst_n,
  input wire                                    out_valid,
  input wire                                    out_stall,
  input wire logic signed [bdq_pkg::DATA_W-1:0] out_read_value,
  input wire logic [bdq_pkg::ST_W-1:0]          out_status,
  input wire logic [CNT_W-1:0]                  out_occupancy
);
  import bdq_pkg::*;

  logic [CNT_W-1:0] last_occ_r, last_occ_nxt;
  logic             seen_r, seen_nxt;
  logic             out_beat;
  logic             step_ok;

  assign out_beat = out_valid & ~out_stall;

  always_comb begin
    last_occ_nxt = last_occ_r;
    seen_nxt     = seen_r;
    if (out_beat) begin
      last_occ_nxt = out_occupancy;
      seen_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      last_occ_r <= '0;
    end else begin
      seen_r     <= seen_nxt;
      last_occ_r <= last_occ_nxt;
    end
  end

  // Each beat adds or removes at most one element
  assign step_ok = (out_occupancy == last_occ_r) ||
                   (out_occupancy == last_occ_r + CNT_W'(1)) ||
                   (last_occ_r == out_occupancy + CNT_W'(1));

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_occupancy <= CNT_W'(DEPTH)))
    else $error("occupancy above depth");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == CNT_W'(DEPTH)))
    else $error("full status with room left");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty status with elements stored");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_read_value == '0))
    else $error("failed operation returned data");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat && seen_r) |-> step_ok)
    else $error("occupancy jumped by more than one");

endmodule

bind bounded_deque_with_indexed_access_core bdq_checker #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_bdq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_value (out_read_value),
  .out_status     (out_status),
  .out_occupancy  (out_occupancy)
);

`default_nettype wire
